[src/rvx_pkg.sv]
`timescale 1ns / 1ps
package rvx_pkg;

   // Operation codes of the decoded instruction
   typedef enum logic [3:0] {
      MODE_ADD     = 4'd0,
      MODE_SUB     = 4'd1,
      MODE_ADDI    = 4'd2,
      MODE_AND     = 4'd3,
      MODE_OR      = 4'd4,
      MODE_XOR     = 4'd5,
      MODE_ANDI    = 4'd6,
      MODE_ORI     = 4'd7,
      MODE_XORI    = 4'd8,
      MODE_LW      = 4'd9,
      MODE_SW      = 4'd10,
      MODE_BEQ     = 4'd11,
      MODE_BNE     = 4'd12,
      MODE_JAL     = 4'd13,
      MODE_JALR    = 4'd14,
      MODE_INVALID = 4'd15
   } mode_type;

   localparam int REQ_W = 56;
   localparam int RSP_W = 176;

   // Input word, first member in the highest bits so mode lands at bit 0
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] immediate;
      logic [4:0]  dest_reg;
      logic [4:0]  src_reg_b;
      logic [4:0]  src_reg_a;
      mode_type    mode;
   } req_type;

   // Result word, also the payload carried down the pipeline
   typedef struct packed {
      logic [5:0]  pad;
      logic        bad_operation;
      logic [31:0] mem_value;
      logic [31:0] mem_address;
      logic        mem_write;
      logic        mem_read;
      logic [31:0] write_value;
      logic [4:0]  write_index;
      logic        reg_written;
      logic        branch_taken;
      logic [31:0] next_pc;
      logic [31:0] old_pc;
   } rsp_type;

   // Load enables of the address reduction stages
   typedef struct packed {
      logic s3;
      logic s4;
   } adv_type;

endpackage

[src/rvx_ram.sv]
`timescale 1ns / 1ps
module rvx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read old contents on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rvx_alu.sv]
`timescale 1ns / 1ps
module rvx_alu
   import rvx_pkg::*;
(
   input  req_type     item,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [31:0] pc,
   output rsp_type     ex,
   output logic [31:0] pc_next
);

   logic [31:0] sum_ai;
   logic [31:0] pc_plus4;
   logic [31:0] pc_plus_imm;
   logic [31:0] wval;
   logic        writes;

   assign sum_ai      = op_a + item.immediate;
   assign pc_plus4    = pc + 32'd4;
   assign pc_plus_imm = pc + item.immediate;

   // Decode and compute one instruction
   always_comb begin
      ex = '0;
      ex.old_pc = pc;
      pc_next = pc_plus4;
      wval = '0;
      writes = 1'b1;
      case (item.mode)
         MODE_ADD:  wval = op_a + op_b;
         MODE_SUB:  wval = op_a - op_b;
         MODE_ADDI: wval = sum_ai;
         MODE_AND:  wval = op_a & op_b;
         MODE_OR:   wval = op_a | op_b;
         MODE_XOR:  wval = op_a ^ op_b;
         MODE_ANDI: wval = op_a & item.immediate;
         MODE_ORI:  wval = op_a | item.immediate;
         MODE_XORI: wval = op_a ^ item.immediate;
         MODE_LW: begin
            // load data arrives at the memory stage
            ex.mem_address = sum_ai;
            ex.mem_read = 1'b1;
         end
         MODE_SW: begin
            ex.mem_address = sum_ai;
            ex.mem_value = op_b;
            ex.mem_write = 1'b1;
            writes = 1'b0;
         end
         MODE_BEQ, MODE_BNE: begin
            ex.branch_taken = (item.mode == MODE_BEQ) ? (op_a == op_b) : (op_a != op_b);
            if (ex.branch_taken) begin
               pc_next = pc_plus_imm;
            end
            writes = 1'b0;
         end
         MODE_JAL: begin
            wval = pc_plus4;
            pc_next = pc_plus_imm;
         end
         MODE_JALR: begin
            wval = pc_plus4;
            pc_next = {sum_ai[31:1], 1'b0};
         end
         default: begin
            ex.bad_operation = 1'b1;
            pc_next = pc;
            writes = 1'b0;
         end
      endcase
      if (writes) begin
         ex.write_index = item.dest_reg;
         ex.reg_written = (item.dest_reg != 5'd0);
         ex.write_value = wval;
      end
      ex.next_pc = pc_next;
   end

endmodule

[src/rvx_widx.sv]
`timescale 1ns / 1ps
module rvx_widx
   import rvx_pkg::*;
#(
   parameter int DATA_WORDS = 1024
) (
   input  logic                          clock,
   input  adv_type                       adv,
   input  logic [29:0]                   word_s2,
   input  logic [29:0]                   word_s3,
   output logic [$clog2(DATA_WORDS)-1:0] index_s4
);

   localparam int          IDX_W = $clog2(DATA_WORDS);
   localparam logic [29:0] RECIP = 30'((64'd1 << 30) / DATA_WORDS);
   localparam logic [29:0] DW    = 30'(DATA_WORDS);

   logic [59:0] quot_prod;
   logic [59:0] back_prod;
   logic [29:0] quot_ff;
   logic [29:0] quot_in;
   logic [29:0] rem_ff;
   logic [29:0] rem_in;
   logic [29:0] rem_fix;

   // Estimate the quotient by a reciprocal; it is low by at most one
   assign quot_prod = {30'd0, word_s2} * {30'd0, RECIP};
   assign quot_in   = quot_prod[59:30];

   // Remainder below twice the depth
   assign back_prod = {30'd0, quot_ff} * {30'd0, DW};
   assign rem_in    = word_s3 - back_prod[29:0];

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         quot_ff <= quot_in;
      end
      if (adv.s4) begin
         rem_ff <= rem_in;
      end
   end

   // Final correction
   assign rem_fix  = (rem_ff >= DW) ? rem_ff - DW : rem_ff;
   assign index_s4 = rem_fix[IDX_W-1:0];

endmodule

[src/rv32i_subset_execute_stage.sv]
`timescale 1ns / 1ps
// Execute stage for a 15-operation RV32I subset. Each req word is one decoded
// instruction; each rsp word reports old and next pc, the register writeback,
// the data memory access, the branch outcome and an error flag for an
// unsupported mode. The pc, the register file and the data memory live here.
// csr_data loads the pc (start address); write it only while no word is in
// flight. csr_ready is always high.
// Pipeline: execute, two stages that reduce the byte address to a word index
// modulo DATA_WORDS, a memory-address stage and a memory-data stage, then an
// output register. Throughput is one word per cycle while rsp_tready is high;
// a word whose source register is the destination of a load still in the
// three stages after execute waits in execute for the load data. The register
// file sits in two 32-entry RAMs, the data memory in one DATA_WORDS-entry RAM,
// both with registered reads and bypass of writes still in flight.
// Reset clears the pipeline, sets the pc to 0 and starts a clearing pass that
// zeroes every word of the data memory; req_tready stays low meanwhile.
// When rsp_tready is low the output register holds and the pipeline keeps
// taking words until its stages are full.
module rv32i_subset_execute_stage
   import rvx_pkg::*;
#(
   parameter int DATA_WORDS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // mode, src_reg_a, src_reg_b, dest_reg, immediate, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // old_pc, next_pc, branch_taken, reg_written, write_index, write_value,
   // mem_read, mem_write, mem_address, mem_value, bad_operation, zero pad
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int IDX_W = $clog2(DATA_WORDS);

   req_type            req_item;
   req_type            s1_ff;
   logic               v1_ff, v1_in;
   rsp_type            s2_ff, s3_ff, s4_ff, s5_ff;
   logic               v2_ff, v3_ff, v4_ff, v5_ff;
   logic               v2_in, v3_in, v4_in, v5_in;
   logic [IDX_W-1:0]   s5_idx_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        pc_ff, pc_in;

   logic               en_out, en5, en4, en3, en2, en1;
   logic               move1, accept, hazard;

   logic [31:0]        op_a, op_b, pc_next;
   rsp_type            ex;

   logic [31:0]        rf_valid_ff, rf_valid_in;
   logic [31:0]        rf_rdata_a, rf_rdata_b;
   logic [4:0]         rf_raddr_a, rf_raddr_b;
   logic               rf_we;
   logic               rf_last_v_ff;
   logic [4:0]         rf_last_idx_ff;
   logic [31:0]        rf_last_data_ff;

   logic [IDX_W-1:0]   idx_s4;
   logic [IDX_W-1:0]   dm_raddr, dm_waddr;
   logic [31:0]        dm_rdata, dm_wdata, dm_fwd;
   logic               dm_we;
   logic               dm_last_v_ff;
   logic [IDX_W-1:0]   dm_last_idx_ff;
   logic [31:0]        dm_last_data_ff;

   logic               clearing_ff, clearing_in;
   logic [IDX_W-1:0]   clr_idx_ff, clr_idx_in;

   adv_type            adv;

   assign req_item  = req_type'(req_tdata);
   assign csr_ready = 1'b1;

   // Stage enables: a stage loads when empty or when its word moves on
   assign en_out = !rsp_valid_ff || rsp_tready;
   assign en5    = !v5_ff || en_out;
   assign en4    = !v4_ff || en5;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign move1  = v1_ff && en2 && !hazard;
   assign en1    = !v1_ff || move1;
   assign req_tready = en1 && !clearing_ff;
   assign accept = req_tvalid && req_tready;

   // Hold execute while a source waits on a load before its data stage
   always_comb begin
      hazard = 1'b0;
      if (v1_ff) begin
         if (v2_ff && s2_ff.mem_read && s2_ff.reg_written &&
             (s2_ff.write_index == s1_ff.src_reg_a ||
              s2_ff.write_index == s1_ff.src_reg_b)) begin
            hazard = 1'b1;
         end
         if (v3_ff && s3_ff.mem_read && s3_ff.reg_written &&
             (s3_ff.write_index == s1_ff.src_reg_a ||
              s3_ff.write_index == s1_ff.src_reg_b)) begin
            hazard = 1'b1;
         end
         if (v4_ff && s4_ff.mem_read && s4_ff.reg_written &&
             (s4_ff.write_index == s1_ff.src_reg_a ||
              s4_ff.write_index == s1_ff.src_reg_b)) begin
            hazard = 1'b1;
         end
      end
   end

   // Register file read: re-read the held indices while execute stalls
   assign rf_raddr_a = en1 ? req_item.src_reg_a : s1_ff.src_reg_a;
   assign rf_raddr_b = en1 ? req_item.src_reg_b : s1_ff.src_reg_b;

   rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (s5_ff.write_index),
      .wr_data (rsp_in.write_value),
      .rd_addr (rf_raddr_a),
      .rd_data (rf_rdata_a)
   );

   rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (s5_ff.write_index),
      .wr_data (rsp_in.write_value),
      .rd_addr (rf_raddr_b),
      .rd_data (rf_rdata_b)
   );

   // Operand a: youngest pending write wins, then the RAM
   always_comb begin
      if (v2_ff && s2_ff.reg_written && s2_ff.write_index == s1_ff.src_reg_a) begin
         op_a = s2_ff.write_value;
      end else if (v3_ff && s3_ff.reg_written && s3_ff.write_index == s1_ff.src_reg_a) begin
         op_a = s3_ff.write_value;
      end else if (v4_ff && s4_ff.reg_written && s4_ff.write_index == s1_ff.src_reg_a) begin
         op_a = s4_ff.write_value;
      end else if (v5_ff && s5_ff.reg_written && s5_ff.write_index == s1_ff.src_reg_a) begin
         op_a = rsp_in.write_value;
      end else if (rf_last_v_ff && rf_last_idx_ff == s1_ff.src_reg_a) begin
         op_a = rf_last_data_ff;
      end else if (rf_valid_ff[s1_ff.src_reg_a]) begin
         op_a = rf_rdata_a;
      end else begin
         op_a = '0;
      end
   end

   // Operand b: same priority
   always_comb begin
      if (v2_ff && s2_ff.reg_written && s2_ff.write_index == s1_ff.src_reg_b) begin
         op_b = s2_ff.write_value;
      end else if (v3_ff && s3_ff.reg_written && s3_ff.write_index == s1_ff.src_reg_b) begin
         op_b = s3_ff.write_value;
      end else if (v4_ff && s4_ff.reg_written && s4_ff.write_index == s1_ff.src_reg_b) begin
         op_b = s4_ff.write_value;
      end else if (v5_ff && s5_ff.reg_written && s5_ff.write_index == s1_ff.src_reg_b) begin
         op_b = rsp_in.write_value;
      end else if (rf_last_v_ff && rf_last_idx_ff == s1_ff.src_reg_b) begin
         op_b = rf_last_data_ff;
      end else if (rf_valid_ff[s1_ff.src_reg_b]) begin
         op_b = rf_rdata_b;
      end else begin
         op_b = '0;
      end
   end

   rvx_alu u_alu (
      .item    (s1_ff),
      .op_a    (op_a),
      .op_b    (op_b),
      .pc      (pc_ff),
      .ex      (ex),
      .pc_next (pc_next)
   );

   // Reduce the byte address to a word index over stages 2 to 4
   assign adv.s3 = en3;
   assign adv.s4 = en4;

   rvx_widx #(.DATA_WORDS(DATA_WORDS)) u_widx (
      .clock    (clock),
      .adv      (adv),
      .word_s2  (s2_ff.mem_address[31:2]),
      .word_s3  (s3_ff.mem_address[31:2]),
      .index_s4 (idx_s4)
   );

   // Data memory: read from stage 4, write when a store leaves stage 5 or while clearing
   assign dm_raddr = en5 ? idx_s4 : s5_idx_ff;
   assign dm_we    = clearing_ff || (v5_ff && en_out && s5_ff.mem_write);
   assign dm_waddr = clearing_ff ? clr_idx_ff : s5_idx_ff;
   assign dm_wdata = clearing_ff ? 32'd0 : s5_ff.mem_value;

   rvx_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   // Bypass the write made at the edge the read was taken
   assign dm_fwd = (dm_last_v_ff && dm_last_idx_ff == s5_idx_ff) ? dm_last_data_ff : dm_rdata;

   // Finish loads in the data stage
   always_comb begin
      rsp_in = s5_ff;
      if (s5_ff.mem_read) begin
         rsp_in.mem_value = dm_fwd;
         rsp_in.write_value = dm_fwd;
      end
   end

   assign rf_we = v5_ff && en_out && s5_ff.reg_written;

   always_comb begin
      rf_valid_in = rf_valid_ff;
      if (rf_we) begin
         rf_valid_in[s5_ff.write_index] = 1'b1;
      end
   end

   // Clearing pass over the data memory
   always_comb begin
      clr_idx_in = clr_idx_ff + IDX_W'(1);
      clearing_in = clearing_ff && (clr_idx_ff != IDX_W'(DATA_WORDS - 1));
   end

   // Advance valid flags and the pc
   assign v1_in = en1 ? accept : v1_ff;
   assign v2_in = en2 ? move1 : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;
   assign v5_in = en5 ? v4_ff : v5_ff;
   assign rsp_valid_in = en_out ? v5_ff : rsp_valid_ff;

   always_comb begin
      pc_in = pc_ff;
      if (csr_valid) begin
         pc_in = csr_data;
      end else if (move1) begin
         pc_in = pc_next;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff <= '0;
         rf_valid_ff <= '0;
         rf_last_v_ff <= 1'b0;
         dm_last_v_ff <= 1'b0;
         clearing_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff <= pc_in;
         rf_valid_ff <= rf_valid_in;
         rf_last_v_ff <= rf_we;
         dm_last_v_ff <= dm_we;
         clearing_ff <= clearing_in;
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff <= req_item;
      end
      if (en2) begin
         s2_ff <= ex;
      end
      if (en3) begin
         s3_ff <= s2_ff;
      end
      if (en4) begin
         s4_ff <= s3_ff;
      end
      if (en5) begin
         s5_ff <= s4_ff;
         s5_idx_ff <= idx_s4;
      end
      if (en_out) begin
         rsp_ff <= rsp_in;
      end
      rf_last_idx_ff <= s5_ff.write_index;
      rf_last_data_ff <= rsp_in.write_value;
      dm_last_idx_ff <= dm_waddr;
      dm_last_data_ff <= dm_wdata;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // No word may be in flight while the data memory is being cleared
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !(v1_ff || v2_ff || v3_ff || v4_ff || v5_ff || rsp_valid_ff))
      else $error("word in flight during memory clearing");

   // x0 is never written
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> s5_ff.write_index != 5'd0)
      else $error("register file write to x0");

   // A stall of execute is caused only by a load ahead of it
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      hazard |-> ((v2_ff && s2_ff.mem_read) || (v3_ff && s3_ff.mem_read) ||
                  (v4_ff && s4_ff.mem_read)))
      else $error("execute stalled without a pending load");

   // The pc moves only with an executed word or a csr write
   a_pc_moves: assert property (@(posedge clock) disable iff (reset)
      (!move1 && !csr_valid) |=> pc_ff == $past(pc_ff))
      else $error("pc changed without an executed word");

   // An unsupported mode leaves the pc where it was
   a_bad_op_pc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.bad_operation) |-> rsp_ff.next_pc == rsp_ff.old_pc)
      else $error("bad operation changed the pc");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import rvx_pkg::*;

   localparam int MEM_WORDS = 1024;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // mode, src_reg_a, src_reg_b, dest_reg, immediate, zero pad
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // old_pc, next_pc, branch_taken, reg_written, write_index, write_value,
   // mem_read, mem_write, mem_address, mem_value, bad_operation, zero pad
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [31:0]      csr_data   = '0;

   rv32i_subset_execute_stage #(
      .DATA_WORDS(MEM_WORDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Architectural state of the core as the checker sees it
   logic [31:0] arch_pc;
   logic [31:0] arch_regs [32];
   logic [31:0] arch_mem [MEM_WORDS];

   req_type     instr_queue [$];
   rsp_type     predicted_rsp [$];
   int          error_count = 0;
   int          words_sent  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Execute one instruction on the architectural state and return its report
   function automatic rsp_type execute_instr(input req_type w);
      rsp_type     r;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] nxt;
      logic [31:0] wval;
      logic        writes_back;
      int unsigned idx;
      r           = '0;
      a           = (w.src_reg_a == 5'd0) ? 32'd0 : arch_regs[w.src_reg_a];
      b           = (w.src_reg_b == 5'd0) ? 32'd0 : arch_regs[w.src_reg_b];
      nxt         = arch_pc + 32'd4;
      wval        = '0;
      writes_back = 1'b1;
      case (w.mode)
         MODE_ADD:  wval = a + b;
         MODE_SUB:  wval = a - b;
         MODE_ADDI: wval = a + w.immediate;
         MODE_AND:  wval = a & b;
         MODE_OR:   wval = a | b;
         MODE_XOR:  wval = a ^ b;
         MODE_ANDI: wval = a & w.immediate;
         MODE_ORI:  wval = a | w.immediate;
         MODE_XORI: wval = a ^ w.immediate;
         MODE_LW: begin
            r.mem_address = a + w.immediate;
            idx           = (r.mem_address >> 2) % MEM_WORDS;
            r.mem_value   = arch_mem[idx];
            r.mem_read    = 1'b1;
            wval          = r.mem_value;
         end
         MODE_SW: begin
            r.mem_address = a + w.immediate;
            idx           = (r.mem_address >> 2) % MEM_WORDS;
            r.mem_value   = b;
            r.mem_write   = 1'b1;
            arch_mem[idx] = b;
            writes_back   = 1'b0;
         end
         MODE_BEQ, MODE_BNE: begin
            r.branch_taken = (w.mode == MODE_BEQ) ? (a == b) : (a != b);
            if (r.branch_taken) begin
               nxt = arch_pc + w.immediate;
            end
            writes_back = 1'b0;
         end
         MODE_JAL: begin
            wval = arch_pc + 32'd4;
            nxt  = arch_pc + w.immediate;
         end
         MODE_JALR: begin
            wval = arch_pc + 32'd4;
            nxt  = (a + w.immediate) & ~32'd1;
         end
         default: begin
            r.bad_operation = 1'b1;
            nxt             = arch_pc;
            writes_back     = 1'b0;
         end
      endcase
      // x0 still reports index and value but is never written
      if (writes_back) begin
         r.write_index = w.dest_reg;
         r.write_value = wval;
         r.reg_written = (w.dest_reg != 5'd0);
         if (w.dest_reg != 5'd0) begin
            arch_regs[w.dest_reg] = wval;
         end
      end
      r.old_pc  = arch_pc;
      r.next_pc = nxt;
      arch_pc   = nxt;
      return r;
   endfunction

   function automatic req_type instr(input mode_type m, input logic [4:0] ra,
                                     input logic [4:0] rb, input logic [4:0] rd,
                                     input logic [31:0] imm);
      req_type w;
      w           = '0;
      w.mode      = m;
      w.src_reg_a = ra;
      w.src_reg_b = rb;
      w.dest_reg  = rd;
      w.immediate = imm;
      return w;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Offer instruction words in bursts with random gaps; predict on acceptance
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin : drive_req
      req_type nxt_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_rsp.push_back(execute_instr(req_type'(req_tdata)));
            words_sent <= words_sent + 1;
         end
         if (req_tvalid && !req_tready) begin
            // hold the word until it is taken
         end else if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (instr_queue.size() != 0) begin
            nxt_word   = instr_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt_word;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with long hold-offs to back the pipeline up
   int unsigned hold_left = 0;
   int          hold_at   = 150;
   logic [7:0]  rx_cycle  = '0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (words_sent >= hold_at) begin
         hold_left  <= 80;
         hold_at    <= hold_at + 350;
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         case (rx_cycle[7:6])
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= $urandom_range(0, 1);
            2'd2:    rsp_tready <= (rx_cycle % 5) >= 2;
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         if (predicted_rsp.size() == 0) begin
            $display("%0t: unexpected result word, expected none got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = predicted_rsp.pop_front();
            check_field("old_pc", want.old_pc, got.old_pc);
            check_field("next_pc", want.next_pc, got.next_pc);
            check_field("branch_taken", want.branch_taken, got.branch_taken);
            check_field("reg_written", want.reg_written, got.reg_written);
            check_field("write_index", want.write_index, got.write_index);
            check_field("write_value", want.write_value, got.write_value);
            check_field("mem_read", want.mem_read, got.mem_read);
            check_field("mem_write", want.mem_write, got.mem_write);
            check_field("mem_address", want.mem_address, got.mem_address);
            check_field("mem_value", want.mem_value, got.mem_value);
            check_field("bad_operation", want.bad_operation, got.bad_operation);
         end
      end
   end

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (instr_queue.size() != 0 || req_tvalid || predicted_rsp.size() != 0);
      // let the pipeline tail settle
      repeat (8) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] start_values [4];
      logic [31:0] corner_imm [4];
      logic [31:0] small_imm;
      req_type     w;
      int          pick;
      arch_pc       = '0;
      start_values  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'hFFFF_FFFC};
      corner_imm    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      for (int i = 0; i < 32; i++) begin
         arch_regs[i] = '0;
      end
      for (int i = 0; i < MEM_WORDS; i++) begin
         arch_mem[i] = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // wait out the memory clearing pass
      do begin
         @(negedge clock);
      end while (!req_tready);

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         // load the start address; the pc follows at once
         @(posedge clock);
         csr_valid <= 1'b1;
         csr_data  <= start_values[phase];
         do begin
            @(posedge clock);
         end while (!csr_ready);
         arch_pc   = csr_data;
         csr_valid <= 1'b0;
         @(negedge clock);

         if (phase == 0) begin
            // operand extremes and wraparound
            instr_queue.push_back(instr(MODE_ADDI, 5'd0, 5'd0, 5'd1, 32'hFFFF_FFFF));
            instr_queue.push_back(instr(MODE_ADDI, 5'd0, 5'd0, 5'd2, 32'h7FFF_FFFF));
            instr_queue.push_back(instr(MODE_ADD, 5'd1, 5'd2, 5'd3, 32'h0));
            instr_queue.push_back(instr(MODE_SUB, 5'd0, 5'd1, 5'd4, 32'h0));
            instr_queue.push_back(instr(MODE_SUB, 5'd2, 5'd1, 5'd5, 32'h0));
            instr_queue.push_back(instr(MODE_AND, 5'd1, 5'd2, 5'd6, 32'h0));
            instr_queue.push_back(instr(MODE_OR, 5'd5, 5'd4, 5'd7, 32'h0));
            instr_queue.push_back(instr(MODE_XOR, 5'd1, 5'd2, 5'd8, 32'h0));
            instr_queue.push_back(instr(MODE_ANDI, 5'd1, 5'd0, 5'd9, 32'h8000_0000));
            instr_queue.push_back(instr(MODE_ORI, 5'd0, 5'd0, 5'd10, 32'h8000_0000));
            instr_queue.push_back(instr(MODE_XORI, 5'd2, 5'd0, 5'd11, 32'hFFFF_FFFF));
            // write to x0 reports but does not stick
            instr_queue.push_back(instr(MODE_ADDI, 5'd1, 5'd0, 5'd0, 32'd5));
            instr_queue.push_back(instr(MODE_ADD, 5'd0, 5'd0, 5'd12, 32'h0));
            // store at the top word with odd low bits, load back through an alias
            instr_queue.push_back(instr(MODE_SW, 5'd0, 5'd5, 5'd31, 32'hFFFF_FFFF));
            instr_queue.push_back(instr(MODE_LW, 5'd0, 5'd0, 5'd12, 32'h0000_0FFC));
            instr_queue.push_back(instr(MODE_ADD, 5'd12, 5'd12, 5'd13, 32'h0));
            instr_queue.push_back(instr(MODE_SW, 5'd0, 5'd2, 5'd0, 32'h0000_1000));
            instr_queue.push_back(instr(MODE_LW, 5'd0, 5'd0, 5'd0, 32'h0));
            // load feeding a branch right behind it
            instr_queue.push_back(instr(MODE_LW, 5'd4, 5'd0, 5'd14, 32'hFFFF_FFFF));
            instr_queue.push_back(instr(MODE_BEQ, 5'd14, 5'd2, 5'd7, 32'hFFFF_FFF8));
            instr_queue.push_back(instr(MODE_BEQ, 5'd1, 5'd2, 5'd0, 32'h40));
            instr_queue.push_back(instr(MODE_BNE, 5'd1, 5'd2, 5'd0, 32'h7FFF_FFFC));
            instr_queue.push_back(instr(MODE_BNE, 5'd3, 5'd3, 5'd0, 32'h8000_0000));
            instr_queue.push_back(instr(MODE_JAL, 5'd0, 5'd0, 5'd15, 32'hFFFF_FFFC));
            instr_queue.push_back(instr(MODE_JAL, 5'd0, 5'd0, 5'd0, 32'h8000_0000));
            // odd jump target gets bit 0 cleared; source is also the destination
            instr_queue.push_back(instr(MODE_JALR, 5'd1, 5'd0, 5'd16, 32'h0));
            instr_queue.push_back(instr(MODE_JALR, 5'd4, 5'd0, 5'd4, 32'd7));
            instr_queue.push_back(instr(MODE_INVALID, 5'd1, 5'd2, 5'd17, 32'hDEAD_BEEF));
         end

         // random instruction mix, register indexes mostly from a small set
         for (int n = 0; n < 190; n++) begin
            pick        = $urandom_range(0, 99);
            w           = '0;
            w.src_reg_a = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
            w.src_reg_b = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
            w.dest_reg  = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
            w.immediate = $urandom;
            small_imm   = $urandom;
            small_imm   = {{20{small_imm[11]}}, small_imm[11:0]};
            if (pick < 50) begin
               w.mode = mode_type'($urandom_range(MODE_ADD, MODE_XORI));
               case ($urandom_range(0, 3))
                  0:       w.immediate = small_imm;
                  1:       w.immediate = corner_imm[$urandom_range(0, 3)];
                  default: ;
               endcase
            end else if (pick < 68) begin
               w.mode = $urandom_range(0, 1) ? MODE_LW : MODE_SW;
               // aim most accesses at a few words so loads see earlier stores
               if ($urandom_range(0, 9) < 7) begin
                  w.src_reg_a       = 5'd0;
                  w.immediate[11:2] = 10'($urandom_range(0, 15));
                  if ($urandom_range(0, 1)) begin
                     w.immediate[31:12] = '0;
                  end
               end
            end else if (pick < 84) begin
               w.mode = $urandom_range(0, 1) ? MODE_BEQ : MODE_BNE;
               if ($urandom_range(0, 3) == 0) begin
                  w.src_reg_b = w.src_reg_a;
               end
               if ($urandom_range(0, 3) != 0) begin
                  w.immediate = small_imm;
               end
            end else if (pick < 95) begin
               w.mode = $urandom_range(0, 1) ? MODE_JAL : MODE_JALR;
               if ($urandom_range(0, 4) < 3) begin
                  w.immediate = small_imm;
               end
            end else begin
               w.mode = MODE_INVALID;
            end
            instr_queue.push_back(w);
         end
      end

      wait_drained();
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

[filelist.f]
src/rvx_pkg.sv
src/rvx_ram.sv
src/rvx_alu.sv
src/rvx_widx.sv
src/rv32i_subset_execute_stage.sv
tb/testbench.sv
